// ===== rtl/tkh_pkg.sv =====
// Shared widths and defaults for the top-k min-heap selection block.
// No dependencies; every other file of the block imports this package.
package tkh_pkg;

  localparam int PIX_W        = 8;
  localparam int SLOT_W       = 6;
  localparam int CFG_W        = 7;
  localparam int MAX_KEEP_DEF = 64;

endpackage

// ===== rtl/tkh_if.sv =====
// Valid/ready stream interfaces for the pixel input and the kept-value output.
// Depends on tkh_pkg for the payload widths.
interface tkh_pix_if import tkh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             frame_end;

  modport source (output valid, output pixel, output frame_end, input ready);
  modport sink   (input valid, input pixel, input frame_end, output ready);
endinterface

interface tkh_res_if import tkh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PIX_W-1:0]  kept_value;
  logic [SLOT_W-1:0] slot_index;
  logic              run_last;

  modport source (output valid, output kept_value, output slot_index, output run_last,
                  input ready);
  modport sink   (input valid, input kept_value, input slot_index, input run_last,
                  output ready);
endinterface

// ===== rtl/top_k_min_heap_select_core.sv =====
// Top-k selection over a pixel frame: keeps the k largest bytes in a min-heap
// held in a small two-read, one-write memory, and emits them at frame end. Pixels
// arrive one transaction at a time and the block takes no new transaction until
// the current one is fully handled. Filling writes each pixel into the store, plus
// a heap build for the pixel that fills the store. A pixel that does not beat the
// root is compared against it and dropped. One that beats it replaces the root and
// sinks level by level, since the single compare unit reads both children in
// S_SD_RD and chooses and writes in S_SD_CMP for each level. A heap build starts,
// then loads each parent and sinks it the same way. The output run reads and loads
// each result, waiting while a result is held, then clears the store. Entries carry
// valid bits that reset and the end of each run clear at once, so no clearing
// pass is needed.
module top_k_min_heap_select_core import tkh_pkg::*; #(
  parameter int MAX_KEEP = MAX_KEEP_DEF
) (
  input  logic             clk,
  input  logic             rst,
  tkh_pix_if.sink          pix_in,
  tkh_res_if.source        res_out,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data
);

  localparam int KW = $clog2(MAX_KEEP + 1);
  localparam int AW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_PRE      = 4'd1;
  localparam logic [3:0] S_HANDLE   = 4'd2;
  localparam logic [3:0] S_ROOT_RD  = 4'd3;
  localparam logic [3:0] S_ROOT_CMP = 4'd4;
  localparam logic [3:0] S_FIN      = 4'd5;
  localparam logic [3:0] S_BUILD    = 4'd6;
  localparam logic [3:0] S_B_LOAD   = 4'd7;
  localparam logic [3:0] S_B_CUR    = 4'd8;
  localparam logic [3:0] S_SD_RD    = 4'd9;
  localparam logic [3:0] S_SD_CMP   = 4'd10;
  localparam logic [3:0] S_EMIT_RD  = 4'd11;
  localparam logic [3:0] S_EMIT_LD  = 4'd12;
  localparam logic [3:0] S_CLEAR    = 4'd13;

  // Configuration register and its saturated value.
  logic [CFG_W-1:0] keep_count;
  logic [CFG_W-1:0] k_sat;
  logic [KW-1:0]    k_eff;

  // Sequencer registers.
  logic [3:0]        state, state_next;
  logic [3:0]        ret_state, ret_state_next;
  logic              build, build_next;
  logic [KW-1:0]     bidx, bidx_next;
  logic [KW-1:0]     pos, pos_next;
  logic [KW-1:0]     child, child_next;
  logic [PIX_W-1:0]  cur, cur_next;
  logic [PIX_W-1:0]  px, px_next;
  logic              last, last_next;
  logic [KW-1:0]     k_r, k_r_next;
  logic [KW-1:0]     loaded, loaded_next;
  logic [KW-1:0]     emit_idx, emit_idx_next;
  logic              out_valid, out_valid_next;
  logic [PIX_W-1:0]  out_value, out_value_next;
  logic [SLOT_W-1:0] out_slot, out_slot_next;
  logic              out_last, out_last_next;

  // Heap memory, its valid bits and read ports.
  logic [PIX_W-1:0]    heap_mem [MAX_KEEP];
  logic [MAX_KEEP-1:0] slot_valid;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [PIX_W-1:0]    mem_wdata;
  logic                clr;
  logic [AW-1:0]       rd_a_addr, rd_b_addr;
  logic [PIX_W-1:0]    rd_a_data, rd_b_data;
  logic                rd_a_vld, rd_b_vld;
  logic [PIX_W-1:0]    rd_a_val, rd_b_val;

  // Compare unit signals.
  logic [KW:0]       child_w;
  logic              has_right;
  logic              take_right;
  logic [PIX_W-1:0]  min_val;
  logic [KW-1:0]     min_pos;
  logic              sd_finish;
  logic              in_acc;
  logic              out_acc;

  always_comb begin
    k_sat = keep_count;
    if (keep_count == '0) begin
      k_sat = CFG_W'(1);
    end else if (keep_count > CFG_W'(MAX_KEEP)) begin
      k_sat = CFG_W'(MAX_KEEP);
    end
  end
  assign k_eff = k_sat[KW-1:0];

  assign in_acc  = pix_in.valid && pix_in.ready;
  assign out_acc = res_out.valid && res_out.ready;

  assign pix_in.ready       = (state == S_IDLE);
  assign res_out.valid      = out_valid;
  assign res_out.kept_value = out_value;
  assign res_out.slot_index = out_slot;
  assign res_out.run_last   = out_last;

  assign rd_a_val = rd_a_vld ? rd_a_data : '0;
  assign rd_b_val = rd_b_vld ? rd_b_data : '0;

  // 2*pos + 1, and the choice of the smaller child.
  assign child_w    = {pos, 1'b1};
  assign has_right  = (({1'b0, child} + (KW+1)'(1)) < {1'b0, k_r});
  assign take_right = has_right && (rd_a_val > rd_b_val);
  assign min_val    = take_right ? rd_b_val : rd_a_val;
  assign min_pos    = take_right ? (child + KW'(1)) : child;

  always_comb begin
    state_next     = state;
    ret_state_next = ret_state;
    build_next     = build;
    bidx_next      = bidx;
    pos_next       = pos;
    child_next     = child;
    cur_next       = cur;
    px_next        = px;
    last_next      = last;
    k_r_next       = k_r;
    loaded_next    = loaded;
    emit_idx_next  = emit_idx;
    out_valid_next = out_valid && !out_acc;
    out_value_next = out_value;
    out_slot_next  = out_slot;
    out_last_next  = out_last;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    clr            = 1'b0;
    rd_a_addr      = '0;
    rd_b_addr      = '0;
    sd_finish      = 1'b0;

    case (state)
      S_IDLE: begin
        if (in_acc) begin
          px_next    = pix_in.pixel;
          last_next  = pix_in.frame_end;
          k_r_next   = k_eff;
          state_next = S_PRE;
        end
      end
      S_PRE: begin
        // The keep count may have shrunk since the last frame pixel.
        if (loaded > k_r) begin
          loaded_next    = k_r;
          ret_state_next = S_HANDLE;
          state_next     = S_BUILD;
        end else begin
          state_next = S_HANDLE;
        end
      end
      S_HANDLE: begin
        if (loaded < k_r) begin
          mem_we      = 1'b1;
          mem_waddr   = loaded[AW-1:0];
          mem_wdata   = px;
          loaded_next = loaded + KW'(1);
          if ((loaded + KW'(1)) == k_r) begin
            ret_state_next = S_FIN;
            state_next     = S_BUILD;
          end else begin
            state_next = S_FIN;
          end
        end else begin
          state_next = S_ROOT_RD;
        end
      end
      S_ROOT_RD: begin
        rd_a_addr  = '0;
        state_next = S_ROOT_CMP;
      end
      S_ROOT_CMP: begin
        if (px > rd_a_val) begin
          cur_next       = px;
          pos_next       = '0;
          build_next     = 1'b0;
          ret_state_next = S_FIN;
          state_next     = S_SD_RD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!last) begin
          state_next = S_IDLE;
        end else begin
          emit_idx_next = '0;
          if (loaded < k_r) begin
            ret_state_next = S_EMIT_RD;
            state_next     = S_BUILD;
          end else begin
            state_next = S_EMIT_RD;
          end
        end
      end
      S_BUILD: begin
        if (k_r < KW'(2)) begin
          state_next = ret_state;
        end else begin
          bidx_next  = (k_r - KW'(2)) >> 1;
          pos_next   = (k_r - KW'(2)) >> 1;
          build_next = 1'b1;
          state_next = S_B_LOAD;
        end
      end
      S_B_LOAD: begin
        rd_a_addr  = pos[AW-1:0];
        state_next = S_B_CUR;
      end
      S_B_CUR: begin
        cur_next   = rd_a_val;
        state_next = S_SD_RD;
      end
      S_SD_RD: begin
        if (child_w >= {1'b0, k_r}) begin
          sd_finish = 1'b1;
        end else begin
          child_next = child_w[KW-1:0];
          rd_a_addr  = child_w[AW-1:0];
          rd_b_addr  = child_w[AW-1:0] + AW'(1);
          state_next = S_SD_CMP;
        end
      end
      S_SD_CMP: begin
        if (min_val >= cur) begin
          sd_finish = 1'b1;
        end else begin
          // The smaller child moves up; the sifted value stays in cur.
          mem_we     = 1'b1;
          mem_waddr  = pos[AW-1:0];
          mem_wdata  = min_val;
          pos_next   = min_pos;
          state_next = S_SD_RD;
        end
      end
      S_EMIT_RD: begin
        if (!out_valid || res_out.ready) begin
          rd_a_addr  = emit_idx[AW-1:0];
          state_next = S_EMIT_LD;
        end
      end
      S_EMIT_LD: begin
        out_valid_next = 1'b1;
        out_value_next = rd_a_val;
        out_slot_next  = SLOT_W'(emit_idx);
        out_last_next  = ((emit_idx + KW'(1)) == k_r);
        if ((emit_idx + KW'(1)) == k_r) begin
          state_next = S_CLEAR;
        end else begin
          emit_idx_next = emit_idx + KW'(1);
          state_next    = S_EMIT_RD;
        end
      end
      S_CLEAR: begin
        clr         = 1'b1;
        loaded_next = '0;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // End of one sift: park the sifted value and move to the next parent, if any.
    if (sd_finish) begin
      mem_we    = 1'b1;
      mem_waddr = pos[AW-1:0];
      mem_wdata = cur;
      if (build && (bidx != '0)) begin
        bidx_next  = bidx - KW'(1);
        pos_next   = bidx - KW'(1);
        state_next = S_B_LOAD;
      end else begin
        build_next = 1'b0;
        state_next = ret_state;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= CFG_W'(1);
      state      <= S_IDLE;
      ret_state  <= S_IDLE;
      build      <= 1'b0;
      loaded     <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        keep_count <= cfg_wr_data;
      end
      state      <= state_next;
      ret_state  <= ret_state_next;
      build      <= build_next;
      loaded     <= loaded_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    bidx      <= bidx_next;
    pos       <= pos_next;
    child     <= child_next;
    cur       <= cur_next;
    px        <= px_next;
    last      <= last_next;
    k_r       <= k_r_next;
    emit_idx  <= emit_idx_next;
    out_value <= out_value_next;
    out_slot  <= out_slot_next;
    out_last  <= out_last_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      heap_mem[mem_waddr] <= mem_wdata;
    end
    rd_a_data <= heap_mem[rd_a_addr];
    rd_b_data <= heap_mem[rd_b_addr];
  end

  // An entry that has not been written since the last clear reads as zero.
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      slot_valid <= '0;
    end else if (mem_we) begin
      slot_valid[mem_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_a_vld <= slot_valid[rd_a_addr];
    rd_b_vld <= slot_valid[rd_b_addr];
  end

endmodule

// ===== rtl/tkh_checker.sv =====
// Port-level checks for top_k_min_heap_select_core, attached by a bind statement.
// Depends on tkh_pkg for the payload widths.
module tkh_checker import tkh_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [PIX_W-1:0]  kept_value,
  input logic [SLOT_W-1:0] slot_index,
  input logic              run_last
);

  // After each accepted pixel transaction the block is busy and drops input ready.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready straight after an accepted pixel");

  // While a run is still being emitted no new pixel may be taken.
  a_no_input_mid_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !run_last) |-> !in_ready)
    else $error("input ready in the middle of an output run");

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_output_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(kept_value) && $stable(slot_index) && $stable(run_last)))
    else $error("stalled result changed or dropped");

endmodule

bind top_k_min_heap_select_core tkh_checker u_tkh_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (pix_in.valid),
  .in_ready   (pix_in.ready),
  .out_valid  (res_out.valid),
  .out_ready  (res_out.ready),
  .kept_value (res_out.kept_value),
  .slot_index (res_out.slot_index),
  .run_last   (res_out.run_last)
);
